>>> sv/qssi_pkg.sv
// ----------------------------------------------------------------------------
// qssi_pkg: shared definitions for the quad side segment intersect block
// Register indexes of the cell corner registers.
// ----------------------------------------------------------------------------
`default_nettype none

package qssi_pkg;

  // number of corner registers and width of the register index
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned IDX_W    = 3;

  // register index of each corner coordinate
  typedef enum logic [IDX_W-1:0] {
    REG_C0X = 3'd0,
    REG_C0Y = 3'd1,
    REG_C1X = 3'd2,
    REG_C1Y = 3'd3,
    REG_C2X = 3'd4,
    REG_C2Y = 3'd5,
    REG_C3X = 3'd6,
    REG_C3Y = 3'd7
  } reg_idx_e;

endpackage

`default_nettype wire

>>> sv/quad_side_segment_intersect.sv
// ----------------------------------------------------------------------------
// quad_side_segment_intersect: segment crossing test against a quad cell
// Tests a segment against side 1-2, then side 0-3, and flags end inside.
// ----------------------------------------------------------------------------
// Usage:
//   Corners are written through cfg_we_i / cfg_idx_i / cfg_data_i while the
//   block is idle. Segment requests enter on s_axis_*, one result per request
//   leaves on m_axis_*. A new request is taken every cycle while s_axis_tready
//   is high. The path runs through five stages of differences, products,
//   determinants, sign fixup and side select, then one stage per quotient bit
//   in the crossing-point divider, then the output register. Throughput is one
//   request per cycle unless the pipeline is frozen.
//   Reset clears all corners to zero (no hit, no point inside) and empties the
//   pipeline. When the receiver stalls, the output register and a skid entry
//   hold results; s_axis_tready drops once the skid entry fills and the whole
//   pipeline freezes, losing nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_side_segment_intersect #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // config write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [qssi_pkg::IDX_W-1:0]           cfg_idx_i,
  input  wire logic [COORD_WIDTH-1:0]               cfg_data_i,
  // segment requests
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // results
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // hit, hit_side, cross_x, cross_y, end_inside
  output      logic [((2*COORD_WIDTH+3+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned W      = COORD_WIDTH;
  localparam int unsigned DW     = W + 1;
  localparam int unsigned PW     = 2 * W + 2;
  localparam int unsigned NW     = 2 * W + 3;
  localparam int unsigned RW     = 2 * W + 4;
  localparam int unsigned OUT_B  = 2 * W + 3;
  localparam int unsigned OUT_TW = ((OUT_B + 7) / 8) * 8;

  // corner registers
  logic [W-1:0] corner_q [qssi_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < qssi_pkg::NUM_REGS; i++) corner_q[i] <= '0;
    end else if (cfg_we_i) begin
      corner_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  logic signed [DW-1:0] kx [4];
  logic signed [DW-1:0] ky [4];
  assign kx[0] = DW'($signed(corner_q[qssi_pkg::REG_C0X]));
  assign ky[0] = DW'($signed(corner_q[qssi_pkg::REG_C0Y]));
  assign kx[1] = DW'($signed(corner_q[qssi_pkg::REG_C1X]));
  assign ky[1] = DW'($signed(corner_q[qssi_pkg::REG_C1Y]));
  assign kx[2] = DW'($signed(corner_q[qssi_pkg::REG_C2X]));
  assign ky[2] = DW'($signed(corner_q[qssi_pkg::REG_C2Y]));
  assign kx[3] = DW'($signed(corner_q[qssi_pkg::REG_C3X]));
  assign ky[3] = DW'($signed(corner_q[qssi_pkg::REG_C3Y]));

  // pipeline enable: freeze while the skid entry is occupied
  logic en;
  logic skid_valid_q;
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  // input fields
  logic signed [DW-1:0] in_sx, in_sy, in_ex, in_ey;
  assign in_sx = DW'($signed(s_axis_tdata[W-1:0]));
  assign in_sy = DW'($signed(s_axis_tdata[2*W-1:W]));
  assign in_ex = DW'($signed(s_axis_tdata[3*W-1:2*W]));
  assign in_ey = DW'($signed(s_axis_tdata[4*W-1:3*W]));

  // side j: 0 is corner1->corner2, 1 is corner0->corner3
  logic signed [DW-1:0] sax [2], say [2], sbx [2], sby [2];
  assign sax[0] = kx[1]; assign say[0] = ky[1];
  assign sbx[0] = kx[2]; assign sby[0] = ky[2];
  assign sax[1] = kx[0]; assign say[1] = ky[0];
  assign sbx[1] = kx[3]; assign sby[1] = ky[3];

  // ---------------- stage 1: differences ----------------
  logic                 v1_q;
  logic signed [DW-1:0] s1_ex_q [2], s1_ey_q [2], s1_wx_q [2], s1_wy_q [2];
  logic signed [DW-1:0] s1_px_q [4], s1_py_q [4], s1_fx_q [4], s1_fy_q [4];
  logic signed [DW-1:0] s1_dx_q, s1_dy_q;
  logic [W-1:0]         s1_sx_q, s1_sy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        s1_ex_q[j] <= sbx[j] - sax[j];
        s1_ey_q[j] <= sby[j] - say[j];
        s1_wx_q[j] <= in_sx - sax[j];
        s1_wy_q[j] <= in_sy - say[j];
      end
      for (int i = 0; i < 4; i++) begin
        s1_px_q[i] <= in_ex - kx[i];
        s1_py_q[i] <= in_ey - ky[i];
        s1_fx_q[i] <= kx[(i + 1) % 4] - kx[i];
        s1_fy_q[i] <= ky[(i + 1) % 4] - ky[i];
      end
      s1_dx_q <= in_ex - in_sx;
      s1_dy_q <= in_ey - in_sy;
      s1_sx_q <= s_axis_tdata[W-1:0];
      s1_sy_q <= s_axis_tdata[2*W-1:W];
    end
  end

  // ---------------- stage 2: products ----------------
  logic                 v2_q;
  logic signed [PW-1:0] s2_eydx_q [2], s2_exdy_q [2], s2_dxwy_q [2];
  logic signed [PW-1:0] s2_dywx_q [2], s2_exwy_q [2], s2_eywx_q [2];
  logic signed [PW-1:0] s2_ia_q [4], s2_ib_q [4];
  logic signed [DW-1:0] s2_dx_q, s2_dy_q;
  logic [W-1:0]         s2_sx_q, s2_sy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        s2_eydx_q[j] <= s1_ey_q[j] * s1_dx_q;
        s2_exdy_q[j] <= s1_ex_q[j] * s1_dy_q;
        s2_dxwy_q[j] <= s1_dx_q * s1_wy_q[j];
        s2_dywx_q[j] <= s1_dy_q * s1_wx_q[j];
        s2_exwy_q[j] <= s1_ex_q[j] * s1_wy_q[j];
        s2_eywx_q[j] <= s1_ey_q[j] * s1_wx_q[j];
      end
      for (int i = 0; i < 4; i++) begin
        s2_ia_q[i] <= s1_px_q[i] * s1_fy_q[i];
        s2_ib_q[i] <= s1_py_q[i] * s1_fx_q[i];
      end
      s2_dx_q <= s1_dx_q;
      s2_dy_q <= s1_dy_q;
      s2_sx_q <= s1_sx_q;
      s2_sy_q <= s1_sy_q;
    end
  end

  // ---------------- stage 3: determinants and inside test ----------------
  logic                 v3_q;
  logic signed [NW-1:0] s3_det_q [2], s3_n0_q [2], s3_n1_q [2];
  logic                 s3_inside_q;
  logic signed [DW-1:0] s3_dx_q, s3_dy_q;
  logic [W-1:0]         s3_sx_q, s3_sy_q;
  logic signed [NW-1:0] side_c [4];
  logic                 inside_d;

  // sides 0 and 2 include the boundary, sides 1 and 3 do not
  always_comb begin
    inside_d = 1'b1;
    for (int i = 0; i < 4; i++) begin
      side_c[i] = NW'(s2_ia_q[i]) - NW'(s2_ib_q[i]);
      if (i % 2 == 0) inside_d = inside_d & (side_c[i][NW-1] | (side_c[i] == '0));
      else            inside_d = inside_d & side_c[i][NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        s3_det_q[j] <= NW'(s2_eydx_q[j]) - NW'(s2_exdy_q[j]);
        s3_n0_q[j]  <= NW'(s2_dxwy_q[j]) - NW'(s2_dywx_q[j]);
        s3_n1_q[j]  <= NW'(s2_exwy_q[j]) - NW'(s2_eywx_q[j]);
      end
      s3_inside_q <= inside_d;
      s3_dx_q     <= s2_dx_q;
      s3_dy_q     <= s2_dy_q;
      s3_sx_q     <= s2_sx_q;
      s3_sy_q     <= s2_sy_q;
    end
  end

  // ---------------- stage 4: make det positive ----------------
  logic                 v4_q;
  logic signed [NW-1:0] s4_det_q [2], s4_n0_q [2], s4_n1_q [2];
  logic                 s4_nz_q [2];
  logic                 s4_inside_q;
  logic signed [DW-1:0] s4_dx_q, s4_dy_q;
  logic [W-1:0]         s4_sx_q, s4_sy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        s4_nz_q[j] <= (s3_det_q[j] != '0);
        if (s3_det_q[j][NW-1]) begin
          s4_det_q[j] <= -s3_det_q[j];
          s4_n0_q[j]  <= -s3_n0_q[j];
          s4_n1_q[j]  <= -s3_n1_q[j];
        end else begin
          s4_det_q[j] <= s3_det_q[j];
          s4_n0_q[j]  <= s3_n0_q[j];
          s4_n1_q[j]  <= s3_n1_q[j];
        end
      end
      s4_inside_q <= s3_inside_q;
      s4_dx_q     <= s3_dx_q;
      s4_dy_q     <= s3_dy_q;
      s4_sx_q     <= s3_sx_q;
      s4_sy_q     <= s3_sy_q;
    end
  end

  // ---------------- stage 5: range checks, side select ----------------
  logic                 v5_q;
  logic                 s5_hit_q, s5_side_q, s5_negx_q, s5_negy_q, s5_inside_q;
  logic [DW-1:0]        s5_ax_q, s5_ay_q;
  logic [RW-1:0]        s5_n_q, s5_d_q;
  logic [W-1:0]         s5_sx_q, s5_sy_q;
  logic                 side_ok [2];
  logic                 sel;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      side_ok[j] = s4_nz_q[j] &&
                   !s4_n0_q[j][NW-1] && (s4_n0_q[j] <= s4_det_q[j]) &&
                   !s4_n1_q[j][NW-1] && (s4_n1_q[j] <= s4_det_q[j]);
    end
    sel = !side_ok[0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_hit_q    <= side_ok[0] | side_ok[1];
      s5_side_q   <= sel;
      s5_n_q      <= RW'($unsigned(s4_n1_q[sel]));
      s5_d_q      <= RW'($unsigned(s4_det_q[sel]));
      s5_negx_q   <= s4_dx_q[DW-1];
      s5_negy_q   <= s4_dy_q[DW-1];
      s5_ax_q     <= s4_dx_q[DW-1] ? DW'(-s4_dx_q) : DW'(s4_dx_q);
      s5_ay_q     <= s4_dy_q[DW-1] ? DW'(-s4_dy_q) : DW'(s4_dy_q);
      s5_inside_q <= s4_inside_q;
      s5_sx_q     <= s4_sx_q;
      s5_sy_q     <= s4_sy_q;
    end
  end

  // ---------------- crossing-point dividers ----------------
  logic [DW-1:0] qx, qy;

  qssi_muldiv #(.DW(DW), .RW(RW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (s5_ax_q),
    .n_i   (s5_n_q),
    .d_i   (s5_d_q),
    .q_o   (qx)
  );

  qssi_muldiv #(.DW(DW), .RW(RW)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (s5_ay_q),
    .n_i   (s5_n_q),
    .d_i   (s5_d_q),
    .q_o   (qy)
  );

  // side info travels beside the dividers
  logic         dv_valid_q  [DW];
  logic         dv_hit_q    [DW];
  logic         dv_side_q   [DW];
  logic         dv_negx_q   [DW];
  logic         dv_negy_q   [DW];
  logic         dv_inside_q [DW];
  logic [W-1:0] dv_sx_q     [DW];
  logic [W-1:0] dv_sy_q     [DW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_hit_q[0]    <= s5_hit_q;
      dv_side_q[0]   <= s5_side_q;
      dv_negx_q[0]   <= s5_negx_q;
      dv_negy_q[0]   <= s5_negy_q;
      dv_inside_q[0] <= s5_inside_q;
      dv_sx_q[0]     <= s5_sx_q;
      dv_sy_q[0]     <= s5_sy_q;
      for (int k = 1; k < DW; k++) begin
        dv_hit_q[k]    <= dv_hit_q[k-1];
        dv_side_q[k]   <= dv_side_q[k-1];
        dv_negx_q[k]   <= dv_negx_q[k-1];
        dv_negy_q[k]   <= dv_negy_q[k-1];
        dv_inside_q[k] <= dv_inside_q[k-1];
        dv_sx_q[k]     <= dv_sx_q[k-1];
        dv_sy_q[k]     <= dv_sy_q[k-1];
      end
    end
  end

  // valid bits of all stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      for (int k = 0; k < DW; k++) dv_valid_q[k] <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      dv_valid_q[0] <= v5_q;
      for (int k = 1; k < DW; k++) dv_valid_q[k] <= dv_valid_q[k-1];
    end
  end

  // ---------------- final: crossing point ----------------
  logic [DW-1:0]     cx_full, cy_full;
  logic [W-1:0]      cx, cy;
  logic [OUT_TW-1:0] res_d;
  logic              push;

  always_comb begin
    cx_full = DW'($signed(dv_sx_q[DW-1])) + (dv_negx_q[DW-1] ? -qx : qx);
    cy_full = DW'($signed(dv_sy_q[DW-1])) + (dv_negy_q[DW-1] ? -qy : qy);
    cx      = dv_hit_q[DW-1] ? cx_full[W-1:0] : '0;
    cy      = dv_hit_q[DW-1] ? cy_full[W-1:0] : '0;
    res_d   = OUT_TW'({dv_inside_q[DW-1], cy, cx,
                       dv_hit_q[DW-1] & dv_side_q[DW-1], dv_hit_q[DW-1]});
  end

  assign push = en & dv_valid_q[DW-1];

  // ---------------- output register with skid entry ----------------
  logic              out_valid_q;
  logic [OUT_TW-1:0] out_data_q, skid_data_q;
  logic              pop;

  assign pop = out_valid_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_data_q <= skid_data_q;
    end else if (push) begin
      if (out_valid_q && !pop) skid_data_q <= res_d;
      else                     out_data_q  <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> sv/qssi_muldiv.sv
// ----------------------------------------------------------------------------
// qssi_muldiv: pipelined floor(a * n / d) with 0 <= n <= d, d > 0
// One bit of a per stage, DW stages; remainder stays below d after each step.
// ----------------------------------------------------------------------------
`default_nettype none

module qssi_muldiv #(
  parameter int unsigned DW = 33,
  parameter int unsigned RW = 68
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [DW-1:0] a_i,
  input  wire logic [RW-1:0] n_i,
  input  wire logic [RW-1:0] d_i,
  output      logic [DW-1:0] q_o
);

  // per-stage registers
  logic [DW-1:0] a_q [DW];
  logic [DW-1:0] q_q [DW];
  logic [RW-1:0] r_q [DW];
  logic [RW-1:0] n_q [DW];
  logic [RW-1:0] d_q [DW];

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [DW-1:0] a_p, q_p, q_d;
    logic [RW-1:0] r_p, n_p, d_p, r2, r_d, d2;

    if (k == 0) begin : g_first
      assign a_p = a_i;
      assign q_p = '0;
      assign r_p = '0;
      assign n_p = n_i;
      assign d_p = d_i;
    end else begin : g_next
      assign a_p = a_q[k-1];
      assign q_p = q_q[k-1];
      assign r_p = r_q[k-1];
      assign n_p = n_q[k-1];
      assign d_p = d_q[k-1];
    end

    // shift remainder, add n when this bit of a is set, take off d or 2d
    always_comb begin
      r2 = {r_p[RW-2:0], 1'b0} + (a_p[DW-1] ? n_p : '0);
      d2 = {d_p[RW-2:0], 1'b0};
      if (r2 >= d2) begin
        r_d = r2 - d2;
        q_d = {q_p[DW-2:0], 1'b0} + DW'(2);
      end else if (r2 >= d_p) begin
        r_d = r2 - d_p;
        q_d = {q_p[DW-2:0], 1'b0} + DW'(1);
      end else begin
        r_d = r2;
        q_d = {q_p[DW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k] <= {a_p[DW-2:0], 1'b0};
        q_q[k] <= q_d;
        r_q[k] <= r_d;
        n_q[k] <= n_p;
        d_q[k] <= d_p;
      end
    end
  end

  assign q_o = q_q[DW-1];

endmodule

`default_nettype wire

>>> test/quad_side_segment_intersect_test.sv
// ----------------------------------------------------------------------------
// quad_side_segment_intersect_test: self-checking bench for the quad cell
// segment test.
// Loads several cell shapes, from a collapsed cell to corners at the extremes
// of the range. Sends directed and random segments under random backpressure
// on both streams. Each result is checked field by field against an
// exact-integer crossing and inside predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quad_side_segment_intersect_test;

  localparam int unsigned CW      = 32;
  localparam int unsigned LATENCY = CW + 7;
  localparam int unsigned ONE     = 32'h0001_0000;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic          end_in;
    logic [CW-1:0] cy;
    logic [CW-1:0] cx;
    logic          side;
    logic          hit;
  } crossing_t;

  // crossing and inside predictor plus queue of pending crossings
  class crossing_board;
    longint    corner [8];
    crossing_t pending [$];
    int        errors;

    function void set_corner(int idx, logic [CW-1:0] v);
      corner[idx] = longint'($signed(v));
    endfunction

    // parametric crossing of side a-b by segment p + t*d, exact integers
    function bit side_cross(longint ax, longint ay, longint bx, longint by,
                            longint px, longint py, longint dx, longint dy,
                            output longint cx, output longint cy);
      wide_t ex, ey, wx, wy, ddx, ddy, det, n0, n1, q;
      ex = bx - ax; ey = by - ay; wx = px - ax; wy = py - ay;
      ddx = dx; ddy = dy;
      det = ey * ddx - ex * ddy;
      n0  = ddx * wy - ddy * wx;
      n1  = ex * wy - ey * wx;
      cx = 0; cy = 0;
      if (det == 0) return 0;
      if (det < 0) begin
        det = -det; n0 = -n0; n1 = -n1;
      end
      if (n0 < 0 || n0 > det || n1 < 0 || n1 > det) return 0;
      q  = ((ddx < 0 ? -ddx : ddx) * n1) / det;
      cx = px + longint'(ddx < 0 ? -q : q);
      q  = ((ddy < 0 ? -ddy : ddy) * n1) / det;
      cy = py + longint'(ddy < 0 ? -q : q);
      return 1;
    endfunction

    function bit side_ok(longint ax, longint ay, longint bx, longint by,
                         longint px, longint py, bit strict);
      wide_t l, r, a1, a2, b1, b2;
      a1 = px - ax; b1 = by - ay; a2 = py - ay; b2 = bx - ax;
      l = a1 * b1; r = a2 * b2;
      return strict ? (l < r) : (l <= r);
    endfunction

    // note an accepted segment request
    function void note(logic [127:0] d);
      longint sx, sy, ex, ey, cx, cy;
      crossing_t c;
      sx = longint'($signed(d[31:0]));  sy = longint'($signed(d[63:32]));
      ex = longint'($signed(d[95:64])); ey = longint'($signed(d[127:96]));
      c = '0;
      if (side_cross(corner[2], corner[3], corner[4], corner[5], sx, sy,
                     ex - sx, ey - sy, cx, cy)) begin
        c.hit = 1; c.side = 0; c.cx = cx[CW-1:0]; c.cy = cy[CW-1:0];
      end else if (side_cross(corner[0], corner[1], corner[6], corner[7], sx, sy,
                              ex - sx, ey - sy, cx, cy)) begin
        c.hit = 1; c.side = 1; c.cx = cx[CW-1:0]; c.cy = cy[CW-1:0];
      end
      c.end_in = side_ok(corner[0], corner[1], corner[2], corner[3], ex, ey, 0) &&
                 side_ok(corner[2], corner[3], corner[4], corner[5], ex, ey, 1) &&
                 side_ok(corner[4], corner[5], corner[6], corner[7], ex, ey, 0) &&
                 side_ok(corner[6], corner[7], corner[0], corner[1], ex, ey, 1);
      pending.push_back(c);
    endfunction

    // check one result against the oldest pending crossing
    function void check(logic [71:0] d);
      crossing_t got, want;
      got = d[66:0];
      if (pending.size() == 0) begin
        $error("result with nothing pending: %h", d);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit); errors++;
      end
      if (got.side !== want.side) begin
        $error("hit_side: expected %0d, got %0d", want.side, got.side); errors++;
      end
      if (got.cx !== want.cx) begin
        $error("cross_x: expected %h, got %h", want.cx, got.cx); errors++;
      end
      if (got.cy !== want.cy) begin
        $error("cross_y: expected %h, got %h", want.cy, got.cy); errors++;
      end
      if (got.end_in !== want.end_in) begin
        $error("end_inside: expected %0d, got %0d", want.end_in, got.end_in);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i = 0;
  logic                         rst_ni = 1;
  logic                         cfg_we_i = 0;
  logic [qssi_pkg::IDX_W-1:0]   cfg_idx_i = '0;
  logic [CW-1:0]                cfg_data_i = '0;
  logic                         s_axis_tvalid = 0;
  logic                         s_axis_tready;
  logic [127:0]                 s_axis_tdata = '0;   // start_x, start_y, end_x, end_y
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 0;
  logic [71:0]                  m_axis_tdata;   // hit, hit_side, cross_x, cross_y, end_inside

  crossing_board board = new();
  bit stall_armed = 0;

  quad_side_segment_intersect #(.COORD_WIDTH(CW)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // monitors sample the values present before each edge
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) board.note(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) board.check(m_axis_tdata);
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random ready, one long hold-off once armed
  initial begin
    int run, gap, held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      if (stall_armed && !held) begin
        held = 1;
        m_axis_tready <= 0;
        repeat (300) @(posedge clk_i);
      end
      run = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 8);
      m_axis_tready <= 1;
      repeat (run) @(posedge clk_i);
      gap = gap_len();
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // send one segment request; gap precedes it
  task automatic send_seg(logic [31:0] sx, logic [31:0] sy,
                          logic [31:0] ex, logic [31:0] ey, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {ey, ex, sy, sx};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    wait (board.pending.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // load all four corners: x0 y0 x1 y1 x2 y2 x3 y3
  task automatic load_cell(logic [31:0] c [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1;
      cfg_idx_i  <= qssi_pkg::reg_idx_e'(i);
      cfg_data_i <= c[i];
      board.set_corner(i, c[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  // random quad around a center, both windings
  task automatic random_cell(int span, output logic [31:0] c [8]);
    int cx, cy, h;
    bit flip;
    cx = $urandom_range(0, 2 * span) - span;
    cy = $urandom_range(0, 2 * span) - span;
    h  = $urandom_range(span / 8 + 1, span / 2 + 1);
    flip = $urandom_range(0, 1);
    c[0] = cx - h + $urandom_range(0, h / 4); c[1] = cy - h + $urandom_range(0, h / 4);
    c[2] = cx + h - $urandom_range(0, h / 4); c[3] = cy - h + $urandom_range(0, h / 4);
    c[4] = cx + h - $urandom_range(0, h / 4); c[5] = cy + h - $urandom_range(0, h / 4);
    c[6] = cx - h + $urandom_range(0, h / 4); c[7] = cy + h - $urandom_range(0, h / 4);
    if (flip) begin
      {c[0], c[2], c[4], c[6]} = {c[2], c[0], c[6], c[4]};
    end
  endtask

  function automatic logic [31:0] near(logic [31:0] lo, logic [31:0] hi, int m);
    int a, b;
    a = $signed(lo) < $signed(hi) ? $signed(lo) : $signed(hi);
    b = $signed(lo) < $signed(hi) ? $signed(hi) : $signed(lo);
    return a - m + $urandom_range(0, b - a + 2 * m);
  endfunction

  initial begin
    logic [31:0] c [8];
    logic [31:0] p [4];
    int sent;
    rst_ni <= 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // collapsed cell after reset: nothing inside, no crossing
    send_seg(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
    send_seg(0, 0, 0, 0, 0);
    send_seg(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1);
    drain();

    // unit square cell, corners counterclockwise
    c = '{0, 0, ONE, 0, ONE, ONE, 0, ONE};
    load_cell(c);
    send_seg(ONE / 2, ONE / 2, 2 * ONE, ONE / 2, 0);       // crosses side 1-2
    send_seg(ONE / 2, ONE / 3, -ONE, ONE / 3, 0);          // crosses side 0-3
    send_seg(-ONE, ONE / 2, 2 * ONE, ONE / 3, 0);          // both sides: 1-2 wins
    send_seg(ONE / 2, ONE / 2, ONE, ONE / 2, 0);           // ends on side 1-2
    send_seg(ONE, ONE / 2, 2 * ONE, ONE / 2, 0);           // starts on side
    send_seg(2 * ONE, 0, 2 * ONE, ONE, 2);                 // parallel to side
    send_seg(ONE, -ONE, ONE, 2 * ONE, 0);                  // collinear with side
    send_seg(ONE / 4, ONE / 4, ONE / 3, ONE / 5, 0);       // fully inside
    send_seg(ONE / 2, ONE / 2, ONE / 2, 0, 0);             // end on side 0: inside
    send_seg(ONE / 2, ONE / 2, ONE / 2, ONE, 0);           // end on side 2: inside
    send_seg(ONE / 2, ONE / 2, 0, ONE / 2, 0);             // end on side 3: outside
    send_seg(ONE, ONE, ONE, ONE, 0);                       // point segment on corner
    send_seg(3, 7, -5, 11, 0);                             // truncation toward zero
    drain();

    // cell at the extremes of the range
    c = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
          32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    load_cell(c);
    send_seg(0, 0, 32'h7fff_ffff, 32'h1234_5678, 0);
    send_seg(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_seg(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_seg(32'h8000_0001, 0, 32'h8000_0000, 5, 0);
    drain();

    // random phases; long receiver hold-off in the second one
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) begin
        for (int i = 0; i < 8; i++) c[i] = $urandom();
      end else begin
        random_cell(ph % 2 ? 32'h3fff_ffff : 32'h0010_0000, c);
      end
      load_cell(c);
      if (ph == 1) stall_armed = 1;
      for (int n = 0; n < 90; n++) begin
        int k;
        k = $urandom_range(0, 9);
        if (k < 7) begin
          // segments in and around the cell
          p[0] = near(c[0], c[2], 64); p[1] = near(c[1], c[5], 64);
          p[2] = near(c[0], c[4], 4096); p[3] = near(c[1], c[7], 4096);
          if (k == 0) begin
            p[2] = c[2 * $urandom_range(0, 3)];
            p[3] = c[2 * $urandom_range(0, 3) + 1];
          end
        end else begin
          for (int i = 0; i < 4; i++) p[i] = $urandom();
        end
        send_seg(p[0], p[1], p[2], p[3], gap_len());
        sent++;
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
